/* hw/rtl/mse_pkg.sv */
package mse_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    last_key;
  } key_beat_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic                    last_out;
    logic                    overflowed;
  } sort_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_PRIME,
    ST_MERGE,
    ST_EMIT_PRIME,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic pass_first;
    logic pass_next;
    logic block_next;
    logic step;
    logic emit_start;
    logic emit_mode;
    logic emit_step;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single;
    logic block_end;
    logic pass_end;
    logic sort_done;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/mse_ram.sv */
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

/* hw/rtl/mse_ctrl.sv */
module mse_ctrl
  import mse_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   key_valid,
  input  logic   key_last,
  input  stat_t  stat,
  output logic   key_stall,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    key_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        key_stall = 1'b0;
        if (key_valid) begin
          cmd.store = 1'b1;
          if (key_last) begin
            state_next = ST_BEGIN;
          end
        end
      end
      ST_BEGIN: begin
        if (stat.single) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMIT_PRIME;
        end else begin
          cmd.pass_first = 1'b1;
          state_next     = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.step = 1'b1;
        if (stat.block_end) begin
          if (!stat.pass_end) begin
            cmd.block_next = 1'b1;
            state_next     = ST_PRIME;
          end else if (stat.sort_done) begin
            cmd.emit_start = 1'b1;
            state_next     = ST_EMIT_PRIME;
          end else begin
            cmd.pass_next = 1'b1;
            state_next    = ST_PRIME;
          end
        end
      end
      ST_EMIT_PRIME: begin
        cmd.emit_mode = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_mode = 1'b1;
        if (stat.out_free) begin
          cmd.emit_step = 1'b1;
          if (stat.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/mse_dp.sv */
module mse_dp
  import mse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  key_beat_t  key_data,
  input  logic       sort_stall,
  input  cmd_t       cmd,
  output stat_t      stat,
  output logic       sort_valid,
  output sort_beat_t sort_data
);

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [CNT_W-1:0] width;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] e;
  logic             sel;
  logic             em_bank;

  logic [KEY_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic signed [KEY_W-1:0] rd_i, rd_j, merge_key;
  logic             take_right;
  logic [CNT_W-1:0] i_next, j_next, e_inc;

  logic [CNT_W-1:0] lo_sel, w_sel, blk_mid, blk_hi;
  logic [CNT_W:0]   sum1, sum2;

  logic [ADDR_W-1:0] raddr0, raddr1, waddr_a;
  logic              we_a, we_b;
  logic [KEY_W-1:0]  wdata_a;

  // Source bank data for the merge; sel names the bank read this pass.
  assign rd_i = sel ? b_rd0 : a_rd0;
  assign rd_j = sel ? b_rd1 : a_rd1;

  // Left run wins ties, which keeps the sort stable.
  assign take_right = (j < hi) && ((i >= mid) || (rd_j < rd_i));
  assign merge_key  = take_right ? rd_j : rd_i;
  assign i_next     = take_right ? i : i + 1'b1;
  assign j_next     = take_right ? j + 1'b1 : j;
  assign e_inc      = e + 1'b1;

  // Bounds of the next run pair, clipped to the set size.
  always_comb begin
    lo_sel = cmd.block_next ? hi : '0;
    if (cmd.pass_first) begin
      w_sel = CNT_W'(1);
    end else if (cmd.pass_next) begin
      w_sel = width << 1;
    end else begin
      w_sel = width;
    end
    sum1    = {1'b0, lo_sel} + {1'b0, w_sel};
    sum2    = sum1 + {1'b0, w_sel};
    blk_mid = (sum1 > {1'b0, count}) ? count : sum1[CNT_W-1:0];
    blk_hi  = (sum2 > {1'b0, count}) ? count : sum2[CNT_W-1:0];
  end

  always_comb begin
    if (cmd.emit_mode) begin
      raddr0 = cmd.emit_step ? e_inc[ADDR_W-1:0] : e[ADDR_W-1:0];
    end else begin
      raddr0 = cmd.step ? i_next[ADDR_W-1:0] : i[ADDR_W-1:0];
    end
    raddr1  = cmd.step ? j_next[ADDR_W-1:0] : j[ADDR_W-1:0];
    we_a    = (cmd.store && (count < CNT_W'(MAX_KEYS))) || (cmd.step && sel);
    we_b    = cmd.step && !sel;
    waddr_a = cmd.store ? count[ADDR_W-1:0] : k[ADDR_W-1:0];
    wdata_a = cmd.store ? key_data.key : merge_key;
  end

  mse_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_bank_a (
    .clk    (clk),
    .we     (we_a),
    .waddr  (waddr_a),
    .wdata  (wdata_a),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (a_rd0),
    .rdata1 (a_rd1)
  );

  mse_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_bank_b (
    .clk    (clk),
    .we     (we_b),
    .waddr  (k[ADDR_W-1:0]),
    .wdata  (merge_key),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (b_rd0),
    .rdata1 (b_rd1)
  );

  always_comb begin
    stat.single    = (count == CNT_W'(1));
    stat.block_end = (k + 1'b1 == hi);
    stat.pass_end  = (hi == count);
    stat.sort_done = ({1'b0, width} << 1) >= {1'b0, count};
    stat.emit_last = (e_inc == count);
    stat.out_free  = !sort_valid || !sort_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.store) begin
      if (count < CNT_W'(MAX_KEYS)) begin
        count <= count + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_valid <= 1'b0;
    end else if (cmd.emit_step) begin
      sort_valid <= 1'b1;
    end else if (!sort_stall) begin
      sort_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_first || cmd.pass_next || cmd.block_next) begin
      i   <= lo_sel;
      k   <= lo_sel;
      j   <= blk_mid;
      mid <= blk_mid;
      hi  <= blk_hi;
    end else if (cmd.step) begin
      i <= i_next;
      j <= j_next;
      k <= k + 1'b1;
    end
    if (cmd.pass_first) begin
      width <= w_sel;
      sel   <= 1'b0;
    end else if (cmd.pass_next) begin
      width <= w_sel;
      sel   <= !sel;
    end
    if (cmd.emit_start) begin
      e       <= '0;
      em_bank <= stat.single ? 1'b0 : !sel;
    end else if (cmd.emit_step) begin
      e <= e_inc;
    end
    if (cmd.emit_step) begin
      sort_data.sorted_key <= em_bank ? b_rd0 : a_rd0;
      sort_data.last_out   <= stat.emit_last;
      sort_data.overflowed <= ovf;
    end
  end

endmodule

/* hw/rtl/merge_sort_engine.sv */
// Channel  Valid       Stall       Payload    Beat
// keys     key_valid   key_stall   key_data   one key, last_key closes the set
// sorted   sort_valid  sort_stall  sort_data  one sorted key with last and overflow
//
// Keys load at one per cycle. The key flagged last starts a bottom-up merge sort
// through two ping-pong RAM banks: each pass merges every run pair in turn, with a
// priming state before each pair, and doubles the run width until the set is one run.
// Results then leave at one per cycle unless sort_stall holds the output register.
// Reset is synchronous and clears the controller, key count, overflow flag and sort_valid.
// key_stall is high from the last key until the final result is in the output register;
// sort_stall holds the output register and pauses the emit.
module merge_sort_engine
  import mse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       key_valid,
  output logic       key_stall,
  input  key_beat_t  key_data,
  output logic       sort_valid,
  input  logic       sort_stall,
  output sort_beat_t sort_data
);

  // The controller sequences load, merge passes and emit; the datapath
  // holds the banks, the run counters and the output register.
  cmd_t  cmd;
  stat_t stat;

  mse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_last  (key_data.last_key),
    .stat      (stat),
    .key_stall (key_stall),
    .cmd       (cmd)
  );

  mse_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .key_data   (key_data),
    .sort_stall (sort_stall),
    .cmd        (cmd),
    .stat       (stat),
    .sort_valid (sort_valid),
    .sort_data  (sort_data)
  );

endmodule
